// File: rtl/tdrc_pkg.sv
package tdrc_pkg;

  localparam int unsigned HDR_LEN = 54;
  localparam int unsigned POS_W   = 6;

  localparam logic [POS_W-1:0] HDR_END      = POS_W'(HDR_LEN);
  localparam logic [POS_W-1:0] HDR_LAST     = POS_W'(HDR_LEN - 1);
  localparam logic [POS_W-1:0] ETH_LEN      = 6'd14;
  localparam logic [POS_W-1:0] IP_END       = 6'd34;
  localparam logic [POS_W-1:0] OFF_ETYPE_HI = 6'd12;
  localparam logic [POS_W-1:0] OFF_ETYPE_LO = 6'd13;
  localparam logic [POS_W-1:0] OFF_PROTO    = 6'd23;
  localparam logic [POS_W-1:0] OFF_CSUM_HI  = 6'd24;
  localparam logic [POS_W-1:0] OFF_CSUM_LO  = 6'd25;
  localparam logic [POS_W-1:0] OFF_SRC      = 6'd26;
  localparam logic [POS_W-1:0] OFF_DST      = 6'd30;
  localparam logic [POS_W-1:0] OFF_DST_1    = 6'd31;
  localparam logic [POS_W-1:0] OFF_DST_2    = 6'd32;
  localparam logic [POS_W-1:0] OFF_DST_3    = 6'd33;

  localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
  localparam logic [7:0]  PROTO_TCP      = 8'd6;

  localparam logic [23:0] RST_SERVICE_PREFIX = 24'hAC1300;
  localparam logic [7:0]  RST_HOST_A         = 8'd2;
  localparam logic [7:0]  RST_HOST_B         = 8'd3;
  localparam logic [31:0] RST_TARGET         = 32'hC0A8190A;

  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 32;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_SERVICE_PREFIX = 2'd0,
    REG_HOST_A         = 2'd1,
    REG_HOST_B         = 2'd2,
    REG_TARGET         = 2'd3
  } cfg_reg_t;

  typedef struct packed {
    logic [23:0] service_prefix;
    logic [7:0]  host_a;
    logic [7:0]  host_b;
    logic [31:0] target;
  } cfg_t;

  typedef struct packed {
    logic capture;
    logic decide;
    logic fold;
    logic rd;
    logic load_hdr;
    logic load_pass;
    logic restart;
  } ctrl_cmd_t;

  typedef struct packed {
    logic hdr_full;
    logic rel_last;
    logic ended;
    logic out_free;
  } ctrl_stat_t;

endpackage

// File: rtl/tcp_dest_rewrite_checksum_core.sv
// handover: bytes are held until the 54th header byte or the frame end, then the
// controller steps through decision with checksum add, checksum fold, header read
// and output load before the first held byte is offered
// release: one held byte at a time, by a registered header read and an output load
// pass-through after full header: 1 byte per cycle while the output register is free
// reset (rst, synchronous, active high): controller to holding, counters and output
// valid cleared, config registers to defaults; header memory is not cleared
module tcp_dest_rewrite_checksum_core import tdrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // in_byte
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [7:0]            m_tdata,   // out_byte
  output logic                  m_tlast,
  output logic [1:0]            m_tuser,   // [0] verdict, [1] redirected
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  cfg_t       cfg;
  ctrl_cmd_t  cmd;
  ctrl_stat_t stat;

  tdrc_cfg u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  tdrc_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tlast  (s_tlast),
    .s_tready (s_tready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tdrc_datapath u_dp (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .cmd      (cmd),
    .stat     (stat),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast),
    .m_tuser  (m_tuser)
  );

endmodule

// File: rtl/tdrc_cfg.sv
module tdrc_cfg import tdrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output cfg_t                  cfg
);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.service_prefix <= RST_SERVICE_PREFIX;
      cfg.host_a         <= RST_HOST_A;
      cfg.host_b         <= RST_HOST_B;
      cfg.target         <= RST_TARGET;
    end else if (cfg_we) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_SERVICE_PREFIX: cfg.service_prefix <= cfg_data[23:0];
        REG_HOST_A:         cfg.host_a         <= cfg_data[7:0];
        REG_HOST_B:         cfg.host_b         <= cfg_data[7:0];
        REG_TARGET:         cfg.target         <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

endmodule

// File: rtl/tdrc_ctrl.sv
module tdrc_ctrl import tdrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       s_tvalid,
  input  logic       s_tlast,
  output logic       s_tready,
  input  ctrl_stat_t stat,
  output ctrl_cmd_t  cmd
);

  typedef enum logic [5:0] {
    ST_HOLD   = 6'b000001,
    ST_DECIDE = 6'b000010,
    ST_FOLD   = 6'b000100,
    ST_RD     = 6'b001000,
    ST_LD     = 6'b010000,
    ST_PASS   = 6'b100000
  } state_t;

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_HOLD;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    s_tready   = 1'b0;
    unique case (state)
      ST_HOLD: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          cmd.capture = 1'b1;
          if (s_tlast || stat.hdr_full) state_next = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        cmd.decide = 1'b1;
        state_next = ST_FOLD;
      end
      ST_FOLD: begin
        cmd.fold   = 1'b1;
        state_next = ST_RD;
      end
      ST_RD: begin
        cmd.rd     = 1'b1;
        state_next = ST_LD;
      end
      ST_LD: begin
        if (stat.out_free) begin
          cmd.load_hdr = 1'b1;
          if (!stat.rel_last) begin
            state_next = ST_RD;
          end else if (stat.ended) begin
            cmd.restart = 1'b1;
            state_next  = ST_HOLD;
          end else begin
            state_next = ST_PASS;
          end
        end
      end
      ST_PASS: begin
        s_tready = stat.out_free;
        if (s_tvalid && stat.out_free) begin
          cmd.load_pass = 1'b1;
          if (s_tlast) begin
            cmd.restart = 1'b1;
            state_next  = ST_HOLD;
          end
        end
      end
      default: state_next = ST_HOLD;
    endcase
  end

endmodule

// File: rtl/tdrc_datapath.sv
module tdrc_datapath import tdrc_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cfg_t       cfg,
  input  ctrl_cmd_t  cmd,
  output ctrl_stat_t stat,
  input  logic [7:0] s_tdata,
  input  logic       s_tlast,
  output logic       m_tvalid,
  input  logic       m_tready,
  output logic [7:0] m_tdata,
  output logic       m_tlast,
  output logic [1:0] m_tuser
);

  logic [7:0]       hdr_mem [HDR_LEN];
  logic [7:0]       rdata;
  logic [POS_W-1:0] pos;
  logic [POS_W-1:0] idx;
  logic             ended;
  logic [15:0]      etype;
  logic [7:0]       proto;
  logic [31:0]      src;
  logic [31:0]      dst;
  logic [19:0]      acc;
  logic [19:0]      sum;
  logic [15:0]      csum;
  logic             verdict;
  logic             redirect;
  logic             out_verd;
  logic             out_redir;

  logic             in_csum;
  logic [19:0]      acc_add;
  logic             dst_hit;
  logic             src_out;
  logic             verdict_next;
  logic             redirect_next;
  logic [16:0]      fold1;
  logic [15:0]      fold2;
  logic [7:0]       hdr_byte;
  logic             rel_last;

  // checksum words from the fixed header fields; checksum and destination come later
  assign in_csum = (pos >= ETH_LEN && pos < OFF_CSUM_HI) || (pos >= OFF_SRC && pos < OFF_DST);
  assign acc_add = !in_csum ? 20'd0 :
                   pos[0]   ? {12'd0, s_tdata} : {4'd0, s_tdata, 8'd0};

  assign dst_hit = (dst == {cfg.service_prefix, cfg.host_a}) ||
                   (dst == {cfg.service_prefix, cfg.host_b});
  assign src_out = src[31:8] != cfg.service_prefix;

  always_comb begin
    verdict_next  = 1'b0;
    redirect_next = 1'b0;
    if (pos < ETH_LEN) begin
      verdict_next = 1'b1;
    end else if (etype != ETHERTYPE_IPV4) begin
      verdict_next = 1'b0;
    end else if (pos < IP_END) begin
      verdict_next = 1'b1;
    end else if (proto != PROTO_TCP) begin
      verdict_next = 1'b0;
    end else if (pos < HDR_END) begin
      verdict_next = 1'b1;
    end else begin
      redirect_next = dst_hit && src_out;
    end
  end

  assign fold1 = {1'b0, sum[15:0]} + {13'd0, sum[19:16]};
  assign fold2 = fold1[15:0] + {15'd0, fold1[16]};

  always_comb begin
    hdr_byte = rdata;
    if (redirect) begin
      unique case (idx)
        OFF_CSUM_HI: hdr_byte = csum[15:8];
        OFF_CSUM_LO: hdr_byte = csum[7:0];
        OFF_DST:     hdr_byte = cfg.target[31:24];
        OFF_DST_1:   hdr_byte = cfg.target[23:16];
        OFF_DST_2:   hdr_byte = cfg.target[15:8];
        OFF_DST_3:   hdr_byte = cfg.target[7:0];
        default:     hdr_byte = rdata;
      endcase
    end
  end

  assign rel_last = (idx + 6'd1) == pos;

  assign stat.hdr_full = pos == HDR_LAST;
  assign stat.rel_last = rel_last;
  assign stat.ended    = ended;
  assign stat.out_free = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (cmd.capture) hdr_mem[pos] <= s_tdata;
    if (cmd.rd) rdata <= hdr_mem[idx];
  end

  // header field capture while bytes are held, then the checksum add and fold
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      ended <= s_tlast;
      acc   <= (pos == '0) ? 20'd0 : acc + acc_add;
      if (pos == OFF_ETYPE_HI) etype[15:8] <= s_tdata;
      if (pos == OFF_ETYPE_LO) etype[7:0]  <= s_tdata;
      if (pos == OFF_PROTO) proto <= s_tdata;
      if (pos >= OFF_SRC && pos < OFF_DST) src <= {src[23:0], s_tdata};
      if (pos >= OFF_DST && pos < IP_END) dst <= {dst[23:0], s_tdata};
    end
    if (cmd.decide) begin
      sum <= acc + {4'd0, cfg.target[31:16]} + {4'd0, cfg.target[15:0]};
    end
    if (cmd.fold) csum <= ~fold2;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos      <= '0;
      idx      <= '0;
      verdict  <= 1'b0;
      redirect <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (cmd.capture) pos <= pos + 6'd1;
      if (cmd.decide) begin
        idx      <= '0;
        verdict  <= verdict_next;
        redirect <= redirect_next;
      end
      if (cmd.load_hdr) idx <= idx + 6'd1;
      if (cmd.restart) begin
        pos      <= '0;
        redirect <= 1'b0;
      end
      if (cmd.load_hdr || cmd.load_pass) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_hdr) begin
      m_tdata   <= hdr_byte;
      m_tlast   <= ended && rel_last;
      out_verd  <= ended && rel_last && verdict;
      out_redir <= ended && rel_last && redirect;
    end else if (cmd.load_pass) begin
      m_tdata   <= s_tdata;
      m_tlast   <= s_tlast;
      out_verd  <= 1'b0;
      out_redir <= s_tlast && redirect;
    end
  end

  assign m_tuser = {out_redir, out_verd};

`ifndef NO_ASSERTIONS
  a_capture_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.capture |-> pos < HDR_END)
    else $error("header byte captured past the header store");

  a_pass_after_full: assert property (@(posedge clk) disable iff (rst)
    cmd.load_pass |-> pos == HDR_END)
    else $error("pass-through byte before the full header was released");

  a_release_in_range: assert property (@(posedge clk) disable iff (rst)
    cmd.load_hdr |-> idx < pos)
    else $error("release index beyond held bytes");

  a_flags_on_last: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tlast) |-> (m_tuser == 2'b00))
    else $error("verdict or redirect flag on a byte that is not the last");

  a_redirect_not_aborted: assert property (@(posedge clk) disable iff (rst)
    redirect |-> !verdict)
    else $error("frame both rewritten and aborted");
`endif

endmodule

// File: bench/tdrc_checker.sv
`timescale 1ns / 100ps
module tdrc_checker import tdrc_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // in_byte
  input  logic                  s_tlast,
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [7:0]            m_tdata,   // out_byte
  input  logic                  m_tlast,
  input  logic [1:0]            m_tuser,   // [0] verdict, [1] redirected
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data,
  output int unsigned           mismatches,
  output int unsigned           pending
);

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       aborted;
    logic       redirected;
  } egress_t;

  egress_t          egress_q[$];
  logic [7:0]       held_hdr [0:HDR_LEN-1];
  logic [POS_W-1:0] held_cnt;
  logic             rewrite_on;
  cfg_t             regs;
  int unsigned      bad_cnt = 0;

  // classify the held header and patch destination and checksum on a match
  task automatic judge_header(input int unsigned len, output logic aborted);
    logic [31:0] dst;
    logic [31:0] src;
    logic [19:0] acc;
    logic [15:0] csum;
    aborted = 1'b0;
    rewrite_on = 1'b0;
    if (len < ETH_LEN) begin
      aborted = 1'b1;
      return;
    end
    if ({held_hdr[OFF_ETYPE_HI], held_hdr[OFF_ETYPE_LO]} != ETHERTYPE_IPV4) return;
    if (len < IP_END) begin
      aborted = 1'b1;
      return;
    end
    if (held_hdr[OFF_PROTO] != PROTO_TCP) return;
    if (len < HDR_LEN) begin
      aborted = 1'b1;
      return;
    end
    dst = {held_hdr[OFF_DST], held_hdr[OFF_DST_1], held_hdr[OFF_DST_2], held_hdr[OFF_DST_3]};
    src = {held_hdr[OFF_SRC], held_hdr[OFF_SRC + 1], held_hdr[OFF_SRC + 2],
           held_hdr[OFF_SRC + 3]};
    if (dst != {regs.service_prefix, regs.host_a} &&
        dst != {regs.service_prefix, regs.host_b}) return;
    if (src[31:8] == regs.service_prefix) return;
    held_hdr[OFF_DST]     = regs.target[31:24];
    held_hdr[OFF_DST_1]   = regs.target[23:16];
    held_hdr[OFF_DST_2]   = regs.target[15:8];
    held_hdr[OFF_DST_3]   = regs.target[7:0];
    held_hdr[OFF_CSUM_HI] = 8'h00;
    held_hdr[OFF_CSUM_LO] = 8'h00;
    acc = '0;
    for (int i = ETH_LEN; i < IP_END; i += 2)
      acc = acc + {held_hdr[i], held_hdr[i + 1]};
    repeat (4) if (acc[19:16] != 0) acc = acc[15:0] + acc[19:16];
    csum = ~acc[15:0];
    held_hdr[OFF_CSUM_HI] = csum[15:8];
    held_hdr[OFF_CSUM_LO] = csum[7:0];
    rewrite_on = 1'b1;
  endtask

  always @(posedge clk) begin
    egress_t     got;
    egress_t     want;
    logic        aborted;
    int unsigned len;
    if (rst) begin
      egress_q.delete();
      held_cnt = '0;
      rewrite_on = 1'b0;
      regs = {RST_SERVICE_PREFIX, RST_HOST_A, RST_HOST_B, RST_TARGET};
    end else begin
      if (m_tvalid && m_tready) begin
        got = {m_tdata, m_tlast, m_tuser[0], m_tuser[1]};
        // an item with nothing due compares against unknowns and always fails
        if (egress_q.size() != 0) want = egress_q.pop_front();
        else want = 'x;
        if (got !== want) begin
          if (bad_cnt < 10)
            $display("mismatch: expected byte %h last %b verdict %b redirected %b, %s %h %b %b %b",
                     want.data, want.last, want.aborted, want.redirected, "got",
                     got.data, got.last, got.aborted, got.redirected);
          bad_cnt++;
        end
      end

      if (cfg_we) begin
        case (cfg_index)
          REG_SERVICE_PREFIX: regs.service_prefix = cfg_data[23:0];
          REG_HOST_A:         regs.host_a = cfg_data[7:0];
          REG_HOST_B:         regs.host_b = cfg_data[7:0];
          REG_TARGET:         regs.target = cfg_data;
          default: ;
        endcase
      end

      if (s_tvalid && s_tready) begin
        if (held_cnt == HDR_END) begin
          egress_q.push_back({s_tdata, s_tlast, 1'b0, s_tlast & rewrite_on});
          if (s_tlast) begin
            held_cnt = '0;
            rewrite_on = 1'b0;
          end
        end else begin
          held_hdr[held_cnt] = s_tdata;
          len = held_cnt + 1;
          if (!s_tlast && len < HDR_LEN) begin
            held_cnt = POS_W'(len);
          end else begin
            judge_header(len, aborted);
            for (int i = 0; i < len; i++)
              egress_q.push_back({held_hdr[i], s_tlast && i == len - 1,
                                  s_tlast && i == len - 1 && aborted,
                                  s_tlast && i == len - 1 && rewrite_on});
            if (s_tlast) begin
              held_cnt = '0;
              rewrite_on = 1'b0;
            end else begin
              held_cnt = HDR_END;
            end
          end
        end
      end
    end
    mismatches <= bad_cnt;
    pending <= egress_q.size();
  end

endmodule

// File: bench/testbench.sv
`timescale 1ns / 100ps
module testbench;
  import tdrc_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 400000;
  localparam int unsigned PHASE_BYTES = 45;
  localparam int unsigned SETTLE      = 12;

  logic                  clk;
  logic                  rst;
  logic                  s_tvalid;
  logic                  s_tready;
  logic [7:0]            s_tdata;
  logic                  s_tlast;
  logic                  m_tvalid;
  logic                  m_tready;
  logic [7:0]            m_tdata;
  logic                  m_tlast;
  logic [1:0]            m_tuser;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int unsigned           mismatches;
  int unsigned           pending;

  int unsigned cycles = 0;
  int unsigned stall_left;
  logic        calm;
  logic        rx_quiet;
  logic        tx_gaps;
  logic [7:0]  pkt [0:127];
  cfg_t        live;

  tcp_dest_rewrite_checksum_core uut (.*);
  tdrc_checker chk (.*);

  always begin
    clk = 1'b0;
    #5;
    clk = 1'b1;
    #5;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("tcp_dest_rewrite_checksum_core verification failed");
      $finish;
    end
  end

  // output back-pressure in bursts, with quiet stretches
  always @(posedge clk) begin
    if (calm || rx_quiet) begin
      m_tready <= 1'b1;
    end else if (stall_left != 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 6) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 17);
    end else begin
      m_tready <= 1'b1;
    end
    if ($urandom_range(0, 299) == 0) rx_quiet <= ~rx_quiet;
  end

  task automatic push_byte(input logic [7:0] b, input logic last);
    int unsigned gap;
    s_tvalid <= 1'b1;
    s_tdata <= b;
    s_tlast <= last;
    do @(posedge clk); while (!s_tready);
    if (tx_gaps && !calm && $urandom_range(0, 5) == 0) begin
      gap = $urandom_range(1, 18);
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending until every predicted item has come out
  task automatic drain();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic send_frame(input int len, input int hold_at);
    tx_gaps = ($urandom_range(0, 2) != 0);
    for (int i = 0; i < len; i++) begin
      if (i == hold_at) drain();
      push_byte(pkt[i], i == len - 1);
    end
  endtask

  task automatic fill_header(input logic [15:0] etype, input logic [7:0] proto,
                             input logic [31:0] src, input logic [31:0] dst);
    foreach (pkt[i]) pkt[i] = 8'($urandom);
    pkt[OFF_ETYPE_HI] = etype[15:8];
    pkt[OFF_ETYPE_LO] = etype[7:0];
    pkt[OFF_PROTO] = proto;
    for (int k = 0; k < 4; k++) begin
      pkt[OFF_SRC + k] = src[31 - 8 * k -: 8];
      pkt[OFF_DST + k] = dst[31 - 8 * k -: 8];
    end
  endtask

  task automatic write_regs(input cfg_t v);
    drain();
    repeat (SETTLE) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= REG_SERVICE_PREFIX;
    cfg_data <= 32'(v.service_prefix);
    @(posedge clk);
    cfg_index <= REG_HOST_A;
    cfg_data <= 32'(v.host_a);
    @(posedge clk);
    cfg_index <= REG_HOST_B;
    cfg_data <= 32'(v.host_b);
    @(posedge clk);
    cfg_index <= REG_TARGET;
    cfg_data <= v.target;
    @(posedge clk);
    cfg_we <= 1'b0;
    live = v;
  endtask

  function automatic cfg_t random_regs();
    cfg_t r;
    r.service_prefix = 24'($urandom);
    r.host_a = 8'($urandom);
    r.host_b = 8'($urandom);
    r.target = $urandom;
    return r;
  endfunction

  // mostly ipv4 tcp aimed at the service hosts, with noise and short frames mixed in
  task automatic random_phase(input cfg_t v);
    int unsigned sent;
    int          len;
    logic [31:0] src;
    logic [31:0] dst;
    logic [15:0] etype;
    logic [7:0]  proto;
    write_regs(v);
    sent = 0;
    while (sent < PHASE_BYTES) begin
      etype = ($urandom_range(0, 9) < 8) ? ETHERTYPE_IPV4 : 16'($urandom);
      proto = ($urandom_range(0, 9) < 8) ? PROTO_TCP : 8'($urandom);
      dst = $urandom;
      if ($urandom_range(0, 9) < 7)
        dst = {live.service_prefix, $urandom_range(0, 1) ? live.host_a : live.host_b};
      src = $urandom;
      if ($urandom_range(0, 3) == 0) src[31:8] = live.service_prefix;
      else if (src[31:8] == live.service_prefix) src[31] = ~src[31];
      fill_header(etype, proto, src, dst);
      len = ($urandom_range(0, 4) == 0) ? $urandom_range(1, 53) : $urandom_range(54, 60);
      if ($urandom_range(0, 5) == 0) drain();
      send_frame(len, -1);
      sent += len;
    end
  endtask

  initial begin
    logic [31:0] outside;
    logic [31:0] svc_a;
    logic [31:0] svc_b;
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    m_tready = 1'b0;
    cfg_we = 1'b0;
    cfg_index = REG_SERVICE_PREFIX;
    cfg_data = '0;
    calm = 1'b0;
    rx_quiet = 1'b0;
    tx_gaps = 1'b0;
    stall_left = 0;
    live = {RST_SERVICE_PREFIX, RST_HOST_A, RST_HOST_B, RST_TARGET};
    outside = 32'h0A000001;
    svc_a = {RST_SERVICE_PREFIX, RST_HOST_A};
    svc_b = {RST_SERVICE_PREFIX, RST_HOST_B};
    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // directed frames under the reset register values
    fill_header(ETHERTYPE_IPV4, PROTO_TCP, outside, svc_a);
    send_frame(1, -1);
    send_frame(13, -1);
    fill_header(ETHERTYPE_IPV4, PROTO_TCP, outside, svc_b);
    send_frame(55, 54);

    random_phase(random_regs());
    calm = 1'b1;
    random_phase(random_regs());

    drain();
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && pending == 0)
      $display("tcp_dest_rewrite_checksum_core verification clean");
    else
      $display("tcp_dest_rewrite_checksum_core verification failed");
    $finish;
  end

endmodule

// File: filelist.f
rtl/tdrc_pkg.sv
rtl/tdrc_cfg.sv
rtl/tdrc_ctrl.sv
rtl/tdrc_datapath.sv
rtl/tcp_dest_rewrite_checksum_core.sv
bench/tdrc_checker.sv
bench/testbench.sv
